[design/assert_macros.svh]
// Assertion macros used by the billboard expander RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define PBE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbe assertion failed");

// next-cycle implication, disabled in reset
`define PBE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbe assertion failed");

`endif

[design/pbe_pkg.sv]
// Types and constants of the particle billboard expander.
// No dependencies.
package pbe_pkg;

    localparam int unsigned DIV_STEPS = 16;
    localparam logic [16:0] ONE_Q16   = 17'h10000;
    localparam logic [7:0]  ALPHA_MIN = 8'd2;
    localparam logic [49:0] RND_HALF  = 50'd8192;

    typedef enum logic [2:0] {
        REG_LIFE_SPAN  = 3'd0,
        REG_SIZE_START = 3'd1,
        REG_SIZE_END   = 3'd2,
        REG_RGBA_START = 3'd3,
        REG_RGBA_END   = 3'd4,
        REG_UP_AXIS    = 3'd5,
        REG_RIGHT_AXIS = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [30:0] life_span;
        logic [30:0] size_start;
        logic [30:0] size_end;
        logic [31:0] rgba_start;
        logic [31:0] rgba_end;
        logic [47:0] up_axis;
        logic [47:0] right_axis;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_pos;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] opacity;
    } t_color;

endpackage

[design/pbe_ifs.sv]
// Valid/ready channel interfaces for particle items and vertex items.
// No dependencies.
interface pbe_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] life_left;

    modport source (output valid, pos_x, pos_y, pos_z, life_left, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, life_left, output ready);
endinterface

interface pbe_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic               tex_u;
    logic               tex_v;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         opacity;
    logic               last_corner;

    modport source (output valid, vert_x, vert_y, vert_z, tex_u, tex_v, red, green,
                    blue, opacity, last_corner, input ready);
    modport sink   (input valid, vert_x, vert_y, vert_z, tex_u, tex_v, red, green,
                    blue, opacity, last_corner, output ready);
endinterface

[design/pbe_cfg_regs.sv]
// APB configuration registers of the billboard expander.
// Depends on pbe_pkg.
module pbe_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [5:0]     paddr,
    input  logic [63:0]    pwdata,
    output logic [63:0]    prdata,
    output logic           pready,
    output pbe_pkg::t_cfg  o_cfg
);
    pbe_pkg::t_cfg    r_cfg;
    pbe_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = pbe_pkg::t_reg_idx'(paddr[5:3]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.life_span  <= 31'd65536;
            r_cfg.size_start <= 31'd65536;
            r_cfg.size_end   <= 31'd65536;
            r_cfg.rgba_start <= 32'hFFFF_FFFF;
            r_cfg.rgba_end   <= 32'hFFFF_FF00;
            r_cfg.up_axis    <= 48'h0000_4000_0000;
            r_cfg.right_axis <= 48'h4000_0000_0000;
        end else if (w_wr) begin
            unique case (w_idx)
                pbe_pkg::REG_LIFE_SPAN:  r_cfg.life_span  <= pwdata[30:0];
                pbe_pkg::REG_SIZE_START: r_cfg.size_start <= pwdata[30:0];
                pbe_pkg::REG_SIZE_END:   r_cfg.size_end   <= pwdata[30:0];
                pbe_pkg::REG_RGBA_START: r_cfg.rgba_start <= pwdata[31:0];
                pbe_pkg::REG_RGBA_END:   r_cfg.rgba_end   <= pwdata[31:0];
                pbe_pkg::REG_UP_AXIS:    r_cfg.up_axis    <= pwdata[47:0];
                pbe_pkg::REG_RIGHT_AXIS: r_cfg.right_axis <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            pbe_pkg::REG_LIFE_SPAN:  prdata = {33'd0, r_cfg.life_span};
            pbe_pkg::REG_SIZE_START: prdata = {33'd0, r_cfg.size_start};
            pbe_pkg::REG_SIZE_END:   prdata = {33'd0, r_cfg.size_end};
            pbe_pkg::REG_RGBA_START: prdata = {32'd0, r_cfg.rgba_start};
            pbe_pkg::REG_RGBA_END:   prdata = {32'd0, r_cfg.rgba_end};
            pbe_pkg::REG_UP_AXIS:    prdata = {16'd0, r_cfg.up_axis};
            pbe_pkg::REG_RIGHT_AXIS: prdata = {16'd0, r_cfg.right_axis};
            default:                 prdata = 64'd0;
        endcase
    end
endmodule

[design/pbe_age_div.sv]
// Input register and pipelined restoring divider giving the Q1.16 age factor.
// Depends on pbe_pkg and pbe_ifs.
module pbe_age_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  pbe_pkg::t_cfg i_cfg,
    pbe_in_if.sink        i_part,
    output logic          o_vld,
    output pbe_pkg::t_pos o_pos,
    output logic [16:0]   o_fac
);
    localparam int unsigned N = pbe_pkg::DIV_STEPS;

    typedef struct packed {
        pbe_pkg::t_pos pos;
        logic [30:0]   rem;
        logic [15:0]   quo;
        logic          fz;
    } t_dstg;

    logic  r_vld [0:N];
    t_dstg r_stg [0:N];
    t_dstg n_stg0;
    logic  w_live;

    assign i_part.ready = i_adv;
    assign w_live = !i_part.life_left[31] && (i_part.life_left != 32'sd0);

    always_comb begin
        n_stg0.pos.pos_x = i_part.pos_x;
        n_stg0.pos.pos_y = i_part.pos_y;
        n_stg0.pos.pos_z = i_part.pos_z;
        n_stg0.quo = '0;
        // ratio of one or more, or no span: factor is zero
        n_stg0.fz  = (i_cfg.life_span == 31'd0) ||
                     (i_part.life_left[30:0] >= i_cfg.life_span);
        n_stg0.rem = n_stg0.fz ? 31'd0 : i_part.life_left[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_adv) begin
            r_vld[0] <= i_part.valid && w_live;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_stg[0] <= n_stg0;
        end
    end

    for (genvar k = 1; k <= N; k++) begin : g_step
        logic [31:0] w_sh;
        logic        w_ge;
        t_dstg       n_stg;

        always_comb begin
            w_sh  = {r_stg[k-1].rem, 1'b0};
            w_ge  = w_sh >= {1'b0, i_cfg.life_span};
            n_stg = r_stg[k-1];
            n_stg.rem = w_ge ? 31'(w_sh - {1'b0, i_cfg.life_span}) : w_sh[30:0];
            n_stg.quo = {r_stg[k-1].quo[14:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_adv) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_stg[k] <= n_stg;
            end
        end
    end

    assign o_vld = r_vld[N];
    assign o_pos = r_stg[N].pos;
    assign o_fac = r_stg[N].fz ? 17'd0 : 17'(pbe_pkg::ONE_Q16 - {1'b0, r_stg[N].quo});
endmodule

[design/pbe_blend.sv]
// Two-stage linear blend of color and half-size by the age factor; drops faint items.
// Depends on pbe_pkg.
module pbe_blend (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  pbe_pkg::t_cfg  i_cfg,
    input  logic           i_vld,
    input  pbe_pkg::t_pos  i_pos,
    input  logic [16:0]    i_fac,
    output logic           o_vld,
    output pbe_pkg::t_pos  o_pos,
    output pbe_pkg::t_color o_col,
    output logic [30:0]    o_size
);
    logic          r_vld1;
    pbe_pkg::t_pos r_pos1;
    logic [47:0]   r_sa;
    logic [47:0]   r_sb;
    logic [24:0]   r_ca [0:3];
    logic [24:0]   r_cb [0:3];
    logic [16:0]   w_inv;

    logic            r_vld2;
    pbe_pkg::t_pos   r_pos2;
    pbe_pkg::t_color r_col2;
    logic [30:0]     r_size2;
    logic [7:0]      w_ch [0:3];
    logic [48:0]     w_ssum;

    assign w_inv = 17'(pbe_pkg::ONE_Q16 - i_fac);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pos1 <= i_pos;
            r_sa   <= 48'(i_cfg.size_start * w_inv);
            r_sb   <= 48'(i_cfg.size_end * i_fac);
            for (int c = 0; c < 4; c++) begin
                r_ca[c] <= 25'(i_cfg.rgba_start[24 - 8*c +: 8] * w_inv);
                r_cb[c] <= 25'(i_cfg.rgba_end[24 - 8*c +: 8] * i_fac);
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_ch[c] = 8'((26'(r_ca[c]) + 26'(r_cb[c]) + 26'd32768) >> 16);
        end
        w_ssum = 49'(r_sa) + 49'(r_sb) + 49'd32768;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pos2         <= r_pos1;
            r_col2.red     <= w_ch[0];
            r_col2.green   <= w_ch[1];
            r_col2.blue    <= w_ch[2];
            r_col2.opacity <= w_ch[3];
            r_size2        <= w_ssum[46:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_adv) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1 && (w_ch[3] > pbe_pkg::ALPHA_MIN);
        end
    end

    assign o_vld  = r_vld2;
    assign o_pos  = r_pos2;
    assign o_col  = r_col2;
    assign o_size = r_size2;
endmodule

[design/pbe_expand.sv]
// Axis scaling stage and four-corner vertex emitter with output register.
// Depends on pbe_pkg, pbe_ifs and assert_macros.svh.
`include "assert_macros.svh"
module pbe_expand (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pbe_pkg::t_cfg   i_cfg,
    input  logic            i_vld,
    input  pbe_pkg::t_pos   i_pos,
    input  pbe_pkg::t_color i_col,
    input  logic [30:0]     i_size,
    output logic            o_adv,
    pbe_out_if.source       o_vert
);
    logic               r_vld;
    pbe_pkg::t_pos      r_pos;
    pbe_pkg::t_color    r_col;
    logic signed [47:0] r_up [0:2];
    logic signed [47:0] r_rt [0:2];
    logic [1:0]         r_corner;

    logic               r_ov;
    logic signed [31:0] r_vx;
    logic signed [31:0] r_vy;
    logic signed [31:0] r_vz;
    logic               r_tu;
    logic               r_tv;
    logic               r_last;
    pbe_pkg::t_color    r_ocol;

    logic               w_load;
    logic               w_up_pos;
    logic               w_rt_pos;
    logic signed [31:0] w_crd [0:2];
    logic signed [31:0] w_p [0:2];

    assign w_load   = !r_ov || o_vert.ready;
    assign o_adv    = !r_vld || (w_load && (r_corner == 2'd3));
    assign w_up_pos = (r_corner == 2'd0) || (r_corner == 2'd3);
    assign w_rt_pos = r_corner[1];
    assign w_p[0]   = r_pos.pos_x;
    assign w_p[1]   = r_pos.pos_y;
    assign w_p[2]   = r_pos.pos_z;

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_pos <= i_pos;
            r_col <= i_col;
            for (int k = 0; k < 3; k++) begin
                r_up[k] <= $signed(i_cfg.up_axis[32 - 16*k +: 16]) * $signed({1'b0, i_size});
                r_rt[k] <= $signed(i_cfg.right_axis[32 - 16*k +: 16]) *
                           $signed({1'b0, i_size});
            end
        end
    end

    always_comb begin
        logic signed [49:0] s;
        logic signed [49:0] t;
        logic signed [35:0] q;
        for (int k = 0; k < 3; k++) begin
            s = $signed({{4{w_p[k][31]}}, w_p[k], 14'd0});
            s = w_up_pos ? s + 50'(r_up[k]) : s - 50'(r_up[k]);
            s = w_rt_pos ? s + 50'(r_rt[k]) : s - 50'(r_rt[k]);
            t = s + $signed(pbe_pkg::RND_HALF);
            q = 36'(t >>> 14);
            if (q > 36'sh0_7FFF_FFFF) begin
                w_crd[k] = 32'sh7FFF_FFFF;
            end else if (q < -36'sh0_8000_0000) begin
                w_crd[k] = 32'sh8000_0000;
            end else begin
                w_crd[k] = q[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= 1'b0;
            r_corner <= 2'd0;
            r_ov     <= 1'b0;
        end else begin
            if (o_adv) begin
                r_vld <= i_vld;
            end
            if (r_vld && w_load) begin
                r_corner <= r_corner + 2'd1;
            end
            if (w_load) begin
                r_ov <= r_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_vld && w_load) begin
            r_vx   <= w_crd[0];
            r_vy   <= w_crd[1];
            r_vz   <= w_crd[2];
            r_tu   <= r_corner[1];
            r_tv   <= r_corner[0] ^ r_corner[1];
            r_last <= (r_corner == 2'd3);
            r_ocol <= r_col;
        end
    end

    assign o_vert.valid       = r_ov;
    assign o_vert.vert_x      = r_vx;
    assign o_vert.vert_y      = r_vy;
    assign o_vert.vert_z      = r_vz;
    assign o_vert.tex_u       = r_tu;
    assign o_vert.tex_v       = r_tv;
    assign o_vert.red         = r_ocol.red;
    assign o_vert.green       = r_ocol.green;
    assign o_vert.blue        = r_ocol.blue;
    assign o_vert.opacity     = r_ocol.opacity;
    assign o_vert.last_corner = r_last;

    `PBE_ASSERT_IMPL(a_idle_corner0, i_clk, i_rst_n, !r_vld, r_corner == 2'd0)
    `PBE_ASSERT_IMPL(a_adv_on_last, i_clk, i_rst_n, r_vld && o_adv, r_corner == 2'd3)
    `PBE_ASSERT_NEXT(a_corner_step, i_clk, i_rst_n, r_vld && w_load,
                     r_ov && (r_corner == 2'($past(r_corner) + 2'd1)))
    `PBE_ASSERT_IMPL(a_last_uv, i_clk, i_rst_n, r_ov && r_last, r_tu && !r_tv)
endmodule

[design/particle_billboard_expander_top.sv]
// Top level of the particle billboard expander: config regs, divider, blend, expand.
// Depends on pbe_pkg, pbe_ifs and the pbe_* modules.
//
//  channel  | dir | protocol      | item
//  i_part   | in  | valid/ready   | pos_x, pos_y, pos_z, life_left
//  o_vert   | out | valid/ready   | vertex, uv, color, last_corner
//  apb      | in  | APB, 64b data | registers at 8*index
//
// Path from accept to first vertex: input reg, 16 divider steps, 2 blend stages,
// axis multiply stage, output reg. A live quad holds the axis stage until its four
// vertices leave (one vertex per cycle while the output is ready); a dropped particle
// costs one pipeline slot. An output stall freezes the pipeline only behind a live quad.
// Synchronous active-low reset; no clearing pass.
module particle_billboard_expander_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pbe_in_if.sink      i_part,
    pbe_out_if.source   o_vert,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    pbe_pkg::t_cfg   w_cfg;
    logic            w_adv;
    logic            w_dvld;
    pbe_pkg::t_pos   w_dpos;
    logic [16:0]     w_fac;
    logic            w_bvld;
    pbe_pkg::t_pos   w_bpos;
    pbe_pkg::t_color w_bcol;
    logic [30:0]     w_bsize;

    pbe_cfg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pbe_age_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_cfg   (w_cfg),
        .i_part  (i_part),
        .o_vld   (w_dvld),
        .o_pos   (w_dpos),
        .o_fac   (w_fac)
    );

    pbe_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_cfg   (w_cfg),
        .i_vld   (w_dvld),
        .i_pos   (w_dpos),
        .i_fac   (w_fac),
        .o_vld   (w_bvld),
        .o_pos   (w_bpos),
        .o_col   (w_bcol),
        .o_size  (w_bsize)
    );

    pbe_expand u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_vld   (w_bvld),
        .i_pos   (w_bpos),
        .i_col   (w_bcol),
        .i_size  (w_bsize),
        .o_adv   (w_adv),
        .o_vert  (o_vert)
    );
endmodule

[dv/pbe_vert_checker.sv]
// Checker for the particle billboard expander: mirrors the register writes,
// predicts the quad of every accepted particle and compares each vertex item.
// Depends on pbe_pkg and the channel interfaces in pbe_ifs.
`timescale 1ns / 100ps

module pbe_vert_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pbe_in_if           part_ch,
    pbe_out_if          vert_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               u;
        logic               v;
        pbe_pkg::t_color    col;
        logic               last;
    } t_vert;

    pbe_pkg::t_cfg regs;
    t_vert quad_q[$];
    t_vert quad[4];
    int    nquad;

    function automatic longint unsigned mix(longint unsigned a, longint unsigned b,
                                            longint unsigned f);
        return (a * (64'd65536 - f) + b * f + 64'd32768) >> 16;
    endfunction

    function automatic logic signed [31:0] corner_coord(longint pos, longint u, longint r,
                                                        longint sz, int su, int sr);
        longint s;
        s = pos * 16384 + su * u * sz + sr * r * sz + 8192;
        s = s >>> 14;
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        return s[31:0];
    endfunction

    // fills quad[] with the expected vertices, returns how many
    function automatic int expand_particle(pbe_pkg::t_cfg c, logic signed [31:0] px,
                                           logic signed [31:0] py, logic signed [31:0] pz,
                                           logic signed [31:0] life, ref t_vert q[4]);
        longint unsigned f, ratio, sz;
        longint unsigned ch[4];
        longint pos[3], ua[3], ra[3];
        int su[4] = '{1, -1, -1, 1};
        int sr[4] = '{-1, -1, 1, 1};
        if (life <= 0) return 0;
        if (c.life_span == 0) begin
            f = 0;
        end else begin
            ratio = (longint'(life) << 16) / c.life_span;
            f = (ratio >= 65536) ? 0 : 65536 - ratio;
        end
        for (int i = 0; i < 4; i++)
            ch[i] = mix(c.rgba_start[24-8*i +: 8], c.rgba_end[24-8*i +: 8], f);
        if (ch[3] <= pbe_pkg::ALPHA_MIN) return 0;
        sz = mix(c.size_start, c.size_end, f);
        pos[0] = px; pos[1] = py; pos[2] = pz;
        for (int k = 0; k < 3; k++) begin
            ua[k] = $signed(c.up_axis[32-16*k +: 16]);
            ra[k] = $signed(c.right_axis[32-16*k +: 16]);
        end
        for (int i = 0; i < 4; i++) begin
            q[i].x = corner_coord(pos[0], ua[0], ra[0], sz, su[i], sr[i]);
            q[i].y = corner_coord(pos[1], ua[1], ra[1], sz, su[i], sr[i]);
            q[i].z = corner_coord(pos[2], ua[2], ra[2], sz, su[i], sr[i]);
            q[i].u = (i >= 2);
            q[i].v = (i == 1 || i == 2);
            q[i].col = '{red: ch[0][7:0], green: ch[1][7:0], blue: ch[2][7:0],
                         opacity: ch[3][7:0]};
            q[i].last = (i == 3);
        end
        return 4;
    endfunction

    assign o_pending = quad_q.size();

    always @(posedge i_clk) begin
        t_vert got, want;
        if (!i_rst_n) begin
            regs <= '{life_span: 31'd65536, size_start: 31'd65536, size_end: 31'd65536,
                      rgba_start: 32'hFFFFFFFF, rgba_end: 32'hFFFFFF00,
                      up_axis: 48'h0000_4000_0000, right_axis: 48'h4000_0000_0000};
            o_fail_count <= 0;
        end else begin
            if (psel && penable && pwrite) begin
                case (pbe_pkg::t_reg_idx'(paddr[5:3]))
                    pbe_pkg::REG_LIFE_SPAN:  regs.life_span  <= pwdata[30:0];
                    pbe_pkg::REG_SIZE_START: regs.size_start <= pwdata[30:0];
                    pbe_pkg::REG_SIZE_END:   regs.size_end   <= pwdata[30:0];
                    pbe_pkg::REG_RGBA_START: regs.rgba_start <= pwdata[31:0];
                    pbe_pkg::REG_RGBA_END:   regs.rgba_end   <= pwdata[31:0];
                    pbe_pkg::REG_UP_AXIS:    regs.up_axis    <= pwdata[47:0];
                    pbe_pkg::REG_RIGHT_AXIS: regs.right_axis <= pwdata[47:0];
                    default: ;
                endcase
            end
            if (part_ch.valid && part_ch.ready) begin
                nquad = expand_particle(regs, part_ch.pos_x, part_ch.pos_y, part_ch.pos_z,
                                        part_ch.life_left, quad);
                for (int i = 0; i < nquad; i++) quad_q = {quad_q, quad[i]};
            end
            if (vert_ch.valid && vert_ch.ready) begin
                got = '{x: vert_ch.vert_x, y: vert_ch.vert_y, z: vert_ch.vert_z,
                        u: vert_ch.tex_u, v: vert_ch.tex_v,
                        col: '{red: vert_ch.red, green: vert_ch.green,
                               blue: vert_ch.blue, opacity: vert_ch.opacity},
                        last: vert_ch.last_corner};
                if (quad_q.size() == 0) begin
                    $display("%0t: unexpected vertex item %p", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = quad_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: vertex mismatch expected %p actual %p",
                                 $time, want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

[dv/tb_particle_billboard_expander_top.sv]
// Testbench top for the particle billboard expander: clock, reset, APB writes,
// bursty particle stimulus and a stalling vertex receiver; verdict from pbe_vert_checker.
// Depends on pbe_pkg, pbe_ifs, pbe_vert_checker and the block.
`timescale 1ns / 100ps

module tb_particle_billboard_expander_top;

    localparam int LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata, prdata;
    logic        pready;
    int          fail_count, pending, cycles;
    logic        hold_req;
    int          burst_left;
    logic [31:0] cur_span;

    pbe_in_if  part_ch();
    pbe_out_if vert_ch();

    particle_billboard_expander_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_part(part_ch), .o_vert(vert_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    pbe_vert_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .part_ch(part_ch), .vert_ch(vert_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: stall pattern re-drawn at random among four modes, plus one long hold-off
    always @(posedge i_clk) begin
        int mode, hold_left, hold_done, tick;
        if (!i_rst_n) begin
            vert_ch.ready <= 1'b0;
            mode = 0; hold_left = 0; hold_done = 0; tick = 0;
        end else begin
            tick++;
            if (tick % 64 == 0) mode = $urandom_range(0, 3);
            if (hold_req && !hold_done) begin
                hold_done = 1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                vert_ch.ready <= 1'b0;
            end else begin
                case (mode)
                    0: vert_ch.ready <= 1'b1;
                    1: vert_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: vert_ch.ready <= (tick % 5 < 2);
                    default: vert_ch.ready <= $urandom_range(0, 1);
                endcase
            end
        end
    end

    task automatic reg_write(pbe_pkg::t_reg_idx idx, logic [63:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 3'b000}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == pbe_pkg::REG_LIFE_SPAN) cur_span = {1'b0, val[30:0]};
    endtask

    task automatic wait_quiet();
        part_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // offers one particle and waits until it is accepted; between bursts it then drops valid for a random pause
    task automatic send_particle(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                 logic [31:0] life);
        part_ch.valid <= 1'b1;
        part_ch.pos_x <= px; part_ch.pos_y <= py; part_ch.pos_z <= pz;
        part_ch.life_left <= life;
        @(posedge i_clk);
        while (!part_ch.ready) @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 3) != 0) begin
                part_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_random(int n);
        logic [31:0] life;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: life = $urandom;
                1: life = 32'h8000_0000 | $urandom;
                default: life = (cur_span == 0) ? $urandom_range(1, 32'h7FFF_FFFF)
                                                : $urandom_range(1, cur_span);
            endcase
            send_particle($urandom, $urandom, $urandom, life);
        end
    endtask

    task automatic random_config();
        reg_write(pbe_pkg::REG_LIFE_SPAN, 64'($urandom_range(1, 300000)));
        reg_write(pbe_pkg::REG_SIZE_START, 64'($urandom_range(0, 32'h0010_0000)));
        reg_write(pbe_pkg::REG_SIZE_END, 64'($urandom_range(0, 32'h0010_0000)));
        reg_write(pbe_pkg::REG_RGBA_START, 64'($urandom));
        reg_write(pbe_pkg::REG_RGBA_END, 64'($urandom));
        reg_write(pbe_pkg::REG_UP_AXIS, {$urandom, $urandom});
        reg_write(pbe_pkg::REG_RIGHT_AXIS, {$urandom, $urandom});
    endtask

    initial begin
        cycles = 0; hold_req = 1'b0; burst_left = 0; cur_span = 65536;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        part_ch.valid = 1'b0; part_ch.pos_x = '0; part_ch.pos_y = '0;
        part_ch.pos_z = '0; part_ch.life_left = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: dead, clamped, faint and half-life particles
        send_particle(0, 0, 0, 0);
        send_particle(1, 2, 3, 32'hFFFF_FFFF);
        send_particle(1, 2, 3, 32'h8000_0000);
        send_particle(32'h0001_0000, 32'hFFFF_0000, 5, 32'h7FFF_FFFF);
        send_particle(7, 8, 9, 65536);
        send_particle(7, 8, 9, 1);
        send_particle(32'h0012_3456, 32'h8765_4321, 0, 32768);
        send_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 65536);
        wait_quiet();

        // extremes: biggest span and sizes, extreme axes, saturation
        reg_write(pbe_pkg::REG_LIFE_SPAN, 64'h7FFF_FFFF);
        reg_write(pbe_pkg::REG_SIZE_START, 64'h7FFF_FFFF);
        reg_write(pbe_pkg::REG_SIZE_END, 64'h7FFF_FFFF);
        reg_write(pbe_pkg::REG_RGBA_START, 64'hFFFF_FFFF);
        reg_write(pbe_pkg::REG_RGBA_END, 64'h0000_0000);
        reg_write(pbe_pkg::REG_UP_AXIS, 64'hFFFF_7FFF_8000_7FFF);
        reg_write(pbe_pkg::REG_RIGHT_AXIS, 64'hFFFF_8000_7FFF_8000);
        reg_write(pbe_pkg::t_reg_idx'(3'd7), 64'h1234_5678);
        send_particle(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h7FFF_FFFF);
        send_particle(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1);
        send_particle(0, 0, 0, 32'h4000_0000);
        send_particle(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'h7FFF_0000);
        wait_quiet();

        // zero life span, zero sizes; faint start alpha
        reg_write(pbe_pkg::REG_LIFE_SPAN, 64'd0);
        reg_write(pbe_pkg::REG_SIZE_START, 64'd0);
        reg_write(pbe_pkg::REG_SIZE_END, 64'd0);
        send_particle(32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 1);
        send_particle(4, 5, 6, 32'h7FFF_FFFF);
        wait_quiet();
        reg_write(pbe_pkg::REG_RGBA_START, 64'h8040_2002);
        send_particle(4, 5, 6, 100);
        wait_quiet();
        reg_write(pbe_pkg::REG_RGBA_START, 64'h8040_2003);
        send_particle(4, 5, 6, 100);
        wait_quiet();

        // smallest span: every live particle clamps to birth values
        reg_write(pbe_pkg::REG_LIFE_SPAN, 64'd1);
        reg_write(pbe_pkg::REG_SIZE_START, 64'h0003_0000);
        send_random(10);
        wait_quiet();

        for (int ph = 0; ph < 5; ph++) begin
            random_config();
            if (ph == 1) hold_req <= 1'b1;
            send_random(15);
            // sender pauses until the quad queue drains
            wait_quiet();
            send_random(15);
            wait_quiet();
        end

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
